// File: hw/rtl/sdio_init_pkg.sv
// Shared constants for the SDIO card initialization sequencer.
`timescale 1ns / 1ps

package sdio_init_pkg;

  // Event kinds on the request side
  localparam logic [1:0] MODE_START    = 2'd0;
  localparam logic [1:0] MODE_COMPLETE = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_OCR_REQUEST     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_READY_RETRY     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP_TIMEOUT    = 8'd3;

  // Configuration reset values
  localparam logic [31:0] OCR_REQUEST_RST     = 32'h00FF_8000;
  localparam logic [7:0]  READY_RETRY_RST     = 8'd100;
  localparam logic [15:0] SETTLE_TICKS_RST    = 16'd10;
  localparam logic [15:0] RESP_TIMEOUT_RST    = 16'd100;

  // SD command numbers
  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
  localparam logic [5:0] CMD_IO_SEND_OCR = 6'd5;
  localparam logic [5:0] CMD_SELECT      = 6'd7;
  localparam logic [5:0] CMD_IO_RW       = 6'd52;

  // CMD52 fields: CCCR bus interface control register, write flag, R5 errors
  localparam logic [31:0] CCCR_BUS_ARG_READ = 32'h0000_0E00;
  localparam logic [31:0] CMD52_WRITE_FLAG  = 32'h8000_0000;
  localparam logic [15:0] R5_ERROR_FLAGS    = 16'hCB00;
  localparam logic [1:0]  BUS_WIDTH_4BIT    = 2'b10;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 64;

endpackage

// File: hw/rtl/sdio_card_init_sequencer.sv
// SDIO card init sequencer: event-driven command FSM with a two-entry result buffer.
`timescale 1ns / 1ps

// Steps an SDIO card through power-up: settle delay, CMD0, settle, CMD5 query,
// repeated CMD5 with the OCR window until the card reports ready, CMD3 (RCA
// capture), CMD7 select, then a CMD52 read and write of the CCCR bus width
// register. Each request is one event (start, command completion or tick) and
// yields exactly one result, which is registered in the output buffer.
// A request can be taken every cycle: the whole state update is combinational
// logic between the phase registers and the result register, and a two-entry
// output buffer (result register plus skid) keeps s_axis_tready high while one
// result waits. Throughput drops below one per cycle only while m_axis_tready
// is held low. Configuration writes are always taken (cfg_ready is tied high).
module sdio_card_init_sequencer
  import sdio_init_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] cmd_timed_out, [32:1] card_response, [39:33] zero
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] issue_command, [6:1] command_index, [38:7] command_argument,
  // [39] finished, [40] outcome, [56:41] relative_address, [57] card_ready,
  // [63:58] zero
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_SETTLE_START  = 4'd1,
    PH_WAIT_GO_IDLE  = 4'd2,
    PH_SETTLE_QUERY  = 4'd3,
    PH_WAIT_QUERY    = 4'd4,
    PH_WAIT_READY    = 4'd5,
    PH_RETRY_GAP     = 4'd6,
    PH_WAIT_ADDR     = 4'd7,
    PH_WAIT_SELECT   = 4'd8,
    PH_WAIT_BUSREAD  = 4'd9,
    PH_WAIT_BUSWRITE = 4'd10
  } phase_t;

  // Configuration registers
  logic [31:0] ocr_request;
  logic [7:0]  ready_retry_limit;
  logic [15:0] settle_ticks;
  logic [15:0] response_timeout_ticks;

  // Sequencer state
  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  attempts_left, attempts_left_next;
  logic [15:0] card_address, card_address_next;
  logic        init_done, init_done_next;

  // Output buffer
  logic [OUT_DATA_W-1:0] out_data, skid_data;
  logic                  out_valid, skid_valid;

  // Request fields
  logic        accept;
  logic [1:0]  mode;
  logic        cmd_timed_out;
  logic [31:0] card_response;

  // Result of this event
  logic        issue_command;
  logic [5:0]  command_index;
  logic [31:0] command_argument;
  logic        finished;
  logic        outcome;
  logic [OUT_DATA_W-1:0] result;

  // Helpers for the event logic
  logic        is_wait, is_delay;
  logic [15:0] tick_inc;
  logic        go_delay, fire;
  phase_t      delay_ph, fire_ph;

  assign cfg_ready      = 1'b1;
  assign s_axis_tready  = !skid_valid;
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign mode           = s_axis_tuser;
  assign cmd_timed_out  = s_axis_tdata[0];
  assign card_response  = s_axis_tdata[32:1];

  assign is_wait  = (phase == PH_WAIT_GO_IDLE) || (phase == PH_WAIT_QUERY) ||
                    (phase == PH_WAIT_READY) || (phase == PH_WAIT_ADDR) ||
                    (phase == PH_WAIT_SELECT) || (phase == PH_WAIT_BUSREAD) ||
                    (phase == PH_WAIT_BUSWRITE);
  assign is_delay = (phase == PH_SETTLE_START) || (phase == PH_SETTLE_QUERY) ||
                    (phase == PH_RETRY_GAP);

  assign tick_inc = (tick_count == TICK_MAX) ? tick_count : tick_count + 16'd1;

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    attempts_left_next = attempts_left;
    card_address_next  = card_address;
    init_done_next     = init_done;
    issue_command      = 1'b0;
    command_index      = '0;
    command_argument   = '0;
    finished           = 1'b0;
    outcome            = 1'b0;
    go_delay           = 1'b0;
    delay_ph           = PH_IDLE;
    fire               = 1'b0;
    fire_ph            = PH_IDLE;

    case (mode)
      MODE_START: begin
        card_address_next  = '0;
        init_done_next     = 1'b0;
        attempts_left_next = '0;
        go_delay           = 1'b1;
        delay_ph           = PH_SETTLE_START;
      end
      MODE_COMPLETE: begin
        if (phase == PH_WAIT_BUSREAD) begin
          if (!cmd_timed_out && (card_response[15:0] & R5_ERROR_FLAGS) == 16'd0) begin
            issue_command    = 1'b1;
            command_index    = CMD_IO_RW;
            command_argument = CMD52_WRITE_FLAG | CCCR_BUS_ARG_READ |
                               {24'd0, card_response[7:2], BUS_WIDTH_4BIT};
            phase_next       = PH_WAIT_BUSWRITE;
            tick_count_next  = '0;
          end else begin
            finished        = 1'b1;
            init_done_next  = 1'b1;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        end else if (phase == PH_WAIT_BUSWRITE) begin
          finished        = 1'b1;
          init_done_next  = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end else if (is_wait) begin
          if (cmd_timed_out) begin
            finished        = 1'b1;
            outcome         = 1'b1;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end else begin
            unique case (phase)
              PH_WAIT_GO_IDLE: begin
                go_delay = 1'b1;
                delay_ph = PH_SETTLE_QUERY;
              end
              PH_WAIT_QUERY: begin
                attempts_left_next = (ready_retry_limit != 8'd0) ?
                                     ready_retry_limit - 8'd1 : 8'd0;
                fire    = 1'b1;
                fire_ph = PH_RETRY_GAP;
              end
              PH_WAIT_READY: begin
                if (card_response[31]) begin
                  issue_command   = 1'b1;
                  command_index   = CMD_SEND_RCA;
                  phase_next      = PH_WAIT_ADDR;
                  tick_count_next = '0;
                end else if (attempts_left == 8'd0) begin
                  finished        = 1'b1;
                  outcome         = 1'b1;
                  phase_next      = PH_IDLE;
                  tick_count_next = '0;
                end else begin
                  attempts_left_next = attempts_left - 8'd1;
                  go_delay           = 1'b1;
                  delay_ph           = PH_RETRY_GAP;
                end
              end
              PH_WAIT_ADDR: begin
                card_address_next = card_response[31:16];
                issue_command     = 1'b1;
                command_index     = CMD_SELECT;
                command_argument  = {card_response[31:16], 16'd0};
                phase_next        = PH_WAIT_SELECT;
                tick_count_next   = '0;
              end
              default: begin
                // select done: read the bus interface control register
                issue_command    = 1'b1;
                command_index    = CMD_IO_RW;
                command_argument = CCCR_BUS_ARG_READ;
                phase_next       = PH_WAIT_BUSREAD;
                tick_count_next  = '0;
              end
            endcase
          end
        end
      end
      MODE_TICK: begin
        if (is_delay) begin
          tick_count_next = tick_inc;
          if (tick_inc >= settle_ticks) begin
            fire    = 1'b1;
            fire_ph = phase;
          end
        end else if (is_wait) begin
          tick_count_next = tick_inc;
          if (tick_inc >= response_timeout_ticks) begin
            // a stalled bus width step still counts as a good run
            finished        = 1'b1;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            if (phase == PH_WAIT_BUSREAD || phase == PH_WAIT_BUSWRITE) begin
              init_done_next = 1'b1;
            end else begin
              outcome = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // zero settle delay issues the next command on the same event
    if (go_delay) begin
      if (settle_ticks == 16'd0) begin
        fire    = 1'b1;
        fire_ph = delay_ph;
      end else begin
        phase_next      = delay_ph;
        tick_count_next = '0;
      end
    end

    if (fire) begin
      issue_command   = 1'b1;
      tick_count_next = '0;
      unique case (fire_ph)
        PH_SETTLE_START: begin
          command_index = CMD_GO_IDLE;
          phase_next    = PH_WAIT_GO_IDLE;
        end
        PH_SETTLE_QUERY: begin
          command_index = CMD_IO_SEND_OCR;
          phase_next    = PH_WAIT_QUERY;
        end
        default: begin
          command_index    = CMD_IO_SEND_OCR;
          command_argument = ocr_request;
          phase_next       = PH_WAIT_READY;
        end
      endcase
    end
  end

  assign result = {6'd0, init_done_next, card_address_next, outcome, finished,
                   command_argument, command_index, issue_command};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocr_request            <= OCR_REQUEST_RST;
      ready_retry_limit      <= READY_RETRY_RST;
      settle_ticks           <= SETTLE_TICKS_RST;
      response_timeout_ticks <= RESP_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OCR_REQUEST:  ocr_request            <= cfg_data;
        REG_READY_RETRY:  ready_retry_limit      <= cfg_data[7:0];
        REG_SETTLE_TICKS: settle_ticks           <= cfg_data[15:0];
        REG_RESP_TIMEOUT: response_timeout_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      attempts_left <= '0;
      card_address  <= '0;
      init_done     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      attempts_left <= attempts_left_next;
      card_address  <= card_address_next;
      init_done     <= init_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_axis_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in front");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("taken request left no pending result");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == 16'd0))
    else $error("tick counter not cleared while idle");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    init_done |-> (phase == PH_IDLE))
    else $error("card marked ready while a run is in progress");
`endif

endmodule

// File: bench/tb_sdio_card_init_sequencer.sv
// Self-checking testbench for the SDIO card init sequencer, with a built-in phase predictor.
`timescale 1ns / 1ps

module tb_sdio_card_init_sequencer
  import sdio_init_pkg::*;
();

  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned RANDOM_PER_BLOCK = 215;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETTLE_START, ST_WAIT_GO_IDLE, ST_SETTLE_QUERY, ST_WAIT_QUERY,
    ST_WAIT_READY, ST_RETRY_GAP, ST_WAIT_ADDR, ST_WAIT_SELECT, ST_WAIT_BUSREAD,
    ST_WAIT_BUSWRITE
  } init_phase_t;

  // result word as packed on m_axis_tdata, MSB first
  typedef struct packed {
    logic [5:0]  pad;
    logic        card_ready;
    logic [15:0] rca;
    logic        outcome;
    logic        finished;
    logic [31:0] arg;
    logic [5:0]  cmd;
    logic        issue;
  } seq_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = MODE_TICK;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  sdio_card_init_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state and its copy of the registers
  init_phase_t ph = ST_IDLE;
  logic [15:0] ticks = '0;
  logic [7:0]  tries_left = '0;
  logic [15:0] rca = '0;
  logic        ready_flag = 1'b0;
  logic [31:0] cfg_ocr = OCR_REQUEST_RST;
  logic [7:0]  cfg_retry = READY_RETRY_RST;
  logic [15:0] cfg_settle = SETTLE_TICKS_RST;
  logic [15:0] cfg_timeout = RESP_TIMEOUT_RST;
  seq_result_t pr;

  seq_result_t pending_results[$];
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cmds_seen = 0;
  int unsigned runs_ok = 0;
  int unsigned runs_timeout = 0;
  int unsigned quiet_cycles = 0;
  seq_result_t got, want;

  function automatic bit in_wait(init_phase_t p);
    return p inside {ST_WAIT_GO_IDLE, ST_WAIT_QUERY, ST_WAIT_READY, ST_WAIT_ADDR,
                     ST_WAIT_SELECT, ST_WAIT_BUSREAD, ST_WAIT_BUSWRITE};
  endfunction

  function automatic bit in_delay(init_phase_t p);
    return p inside {ST_SETTLE_START, ST_SETTLE_QUERY, ST_RETRY_GAP};
  endfunction

  function automatic void issue(logic [5:0] cmd, logic [31:0] arg, init_phase_t nxt);
    pr.issue = 1'b1;
    pr.cmd   = cmd;
    pr.arg   = arg;
    ph       = nxt;
    ticks    = '0;
  endfunction

  function automatic void end_run(logic timed_out);
    pr.finished = 1'b1;
    pr.outcome  = timed_out;
    if (!timed_out) ready_flag = 1'b1;
    ph    = ST_IDLE;
    ticks = '0;
  endfunction

  function automatic void delay_done(init_phase_t d);
    case (d)
      ST_SETTLE_START: issue(CMD_GO_IDLE, '0, ST_WAIT_GO_IDLE);
      ST_SETTLE_QUERY: issue(CMD_IO_SEND_OCR, '0, ST_WAIT_QUERY);
      default:         issue(CMD_IO_SEND_OCR, cfg_ocr, ST_WAIT_READY);
    endcase
  endfunction

  function automatic void begin_delay(init_phase_t d);
    if (cfg_settle == 0) begin
      delay_done(d);
    end else begin
      ph    = d;
      ticks = '0;
    end
  endfunction

  function automatic void complete(logic to, logic [31:0] rsp);
    if (ph == ST_WAIT_BUSREAD) begin
      if (!to && (rsp[15:0] & R5_ERROR_FLAGS) == 0)
        issue(CMD_IO_RW,
              CMD52_WRITE_FLAG | CCCR_BUS_ARG_READ | {24'd0, rsp[7:2], BUS_WIDTH_4BIT},
              ST_WAIT_BUSWRITE);
      else
        end_run(1'b0);
    end else if (ph == ST_WAIT_BUSWRITE) begin
      end_run(1'b0);
    end else if (to) begin
      end_run(1'b1);
    end else begin
      case (ph)
        ST_WAIT_GO_IDLE: begin_delay(ST_SETTLE_QUERY);
        ST_WAIT_QUERY: begin
          tries_left = (cfg_retry != 0) ? cfg_retry - 8'd1 : 8'd0;
          issue(CMD_IO_SEND_OCR, cfg_ocr, ST_WAIT_READY);
        end
        ST_WAIT_READY: begin
          if (rsp[31]) begin
            issue(CMD_SEND_RCA, '0, ST_WAIT_ADDR);
          end else if (tries_left == 0) begin
            end_run(1'b1);
          end else begin
            tries_left--;
            begin_delay(ST_RETRY_GAP);
          end
        end
        ST_WAIT_ADDR: begin
          rca = rsp[31:16];
          issue(CMD_SELECT, {rca, 16'd0}, ST_WAIT_SELECT);
        end
        default: issue(CMD_IO_RW, CCCR_BUS_ARG_READ, ST_WAIT_BUSREAD);
      endcase
    end
  endfunction

  // advances the predictor by one event and returns the result it should produce
  function automatic seq_result_t step_sequencer(logic [1:0] mode, logic to, logic [31:0] rsp);
    pr = '0;
    case (mode)
      MODE_START: begin
        rca        = '0;
        ready_flag = 1'b0;
        tries_left = '0;
        begin_delay(ST_SETTLE_START);
      end
      MODE_COMPLETE: if (in_wait(ph)) complete(to, rsp);
      MODE_TICK: begin
        if (in_delay(ph) || in_wait(ph)) begin
          if (ticks != TICK_MAX) ticks++;
          if (in_delay(ph)) begin
            if (ticks >= cfg_settle) delay_done(ph);
          end else if (ticks >= cfg_timeout) begin
            end_run(!(ph == ST_WAIT_BUSREAD || ph == ST_WAIT_BUSWRITE));
          end
        end
      end
      default: ;
    endcase
    pr.rca        = rca;
    pr.card_ready = ready_flag;
    return pr;
  endfunction

  task automatic send_event(input logic [1:0] mode, input logic to, input logic [31:0] rsp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, rsp, to};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(step_sequencer(mode, to, rsp));
    events_sent++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] ocr, input logic [7:0] retry,
                            input logic [15:0] settle, input logic [15:0] tmo);
    logic [31:0] vals [4];
    logic [CFG_INDEX_W-1:0] ids [4];
    vals = '{ocr, {24'd0, retry}, {16'd0, settle}, {16'd0, tmo}};
    ids  = '{REG_OCR_REQUEST, REG_READY_RETRY, REG_SETTLE_TICKS, REG_RESP_TIMEOUT};
    wait_results_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (ids[i])
        REG_OCR_REQUEST:  cfg_ocr     = vals[i];
        REG_READY_RETRY:  cfg_retry   = vals[i][7:0];
        REG_SETTLE_TICKS: cfg_settle  = vals[i][15:0];
        REG_RESP_TIMEOUT: cfg_timeout = vals[i][15:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed card behavior driven by the predicted phase, with some noise
  task automatic emulate_card_event(output bit counted);
    logic [1:0]  m;
    logic        to;
    logic [31:0] r;
    int          roll;
    roll = $urandom_range(99);
    r    = $urandom;
    to   = ($urandom_range(24) == 0);
    if (roll < 4) begin
      m = 2'($urandom_range(3));
    end else if (roll < 6 || ph == ST_IDLE) begin
      m = MODE_START;
    end else if (in_delay(ph)) begin
      m = (roll < 9) ? MODE_COMPLETE : MODE_TICK;
    end else begin
      m = (roll < 30) ? MODE_TICK : MODE_COMPLETE;
      if (ph == ST_WAIT_READY) r[31] = ($urandom_range(99) < 35);
      if (ph == ST_WAIT_BUSREAD && roll < 80) r[15:0] = r[15:0] & ~R5_ERROR_FLAGS;
    end
    counted = !(m == MODE_RSVD || (m == MODE_COMPLETE && !in_wait(ph)) ||
                (m == MODE_TICK && ph == ST_IDLE));
    send_event(m, to, r);
  endtask

  // reset settle delay of 10 ticks before CMD0
  task automatic test_reset_settle();
    send_event(MODE_START, 1'b0, '0);
    repeat (10) send_event(MODE_TICK, 1'b0, '0);
  endtask

  // whole sequence with zero settle, card ready on the last allowed attempt
  task automatic test_full_init();
    set_config(32'hFFFF_FFFF, 8'd2, 16'd0, 16'hFFFF);
    send_event(MODE_START, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, 32'h7FFF_FFFF);
    send_event(MODE_COMPLETE, 1'b0, 32'h8000_0000);
    send_event(MODE_COMPLETE, 1'b0, 32'hFFFF_0000);
    send_event(MODE_COMPLETE, 1'b0, $urandom);
    send_event(MODE_COMPLETE, 1'b0, 32'h0000_34FF);
    send_event(MODE_COMPLETE, 1'b1, $urandom);
    // restart after success clears the address and ready flag
    send_event(MODE_START, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b1, '0);
  endtask

  // tick timeout, zero retry limit, settle changed in the middle of a delay
  task automatic test_error_paths();
    set_config(32'h0, 8'd0, 16'hFFFF, 16'd1);
    send_event(MODE_START, 1'b0, '0);
    send_event(MODE_TICK, 1'b0, '0);
    set_config(32'h0, 8'd0, 16'd1, 16'd1);
    send_event(MODE_TICK, 1'b0, '0);
    send_event(MODE_TICK, 1'b0, '0);
    send_event(MODE_START, 1'b0, '0);
    send_event(MODE_TICK, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_TICK, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, 32'h7FFF_FFFF);
  endtask

  // bus mode read reporting an R5 error flag skips the write and still succeeds
  task automatic test_bus_read_errors();
    set_config(32'h1234_5678, 8'd255, 16'd0, 16'hFFFF);
    send_event(MODE_START, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, 32'hFFFF_FFFF);
    send_event(MODE_COMPLETE, 1'b0, 32'h5A5A_0000);
    send_event(MODE_COMPLETE, 1'b0, '0);
    send_event(MODE_COMPLETE, 1'b0, 32'h0000_0100);
  endtask

  task automatic test_random_traffic();
    int idle_tab [4];
    int stall_tab [4];
    int useful;
    bit counted;
    logic [7:0]  retry;
    logic [15:0] settle, tmo;
    idle_tab  = '{0, 87, 0, 32};
    stall_tab = '{0, 0, 87, 32};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      for (int b = 0; b < 2; b++) begin
        case ($urandom_range(9))
          0:       retry = 8'd0;
          1:       retry = 8'd255;
          2:       retry = 8'd1;
          default: retry = 8'($urandom_range(2, 6));
        endcase
        settle = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        case ($urandom_range(7))
          0:       tmo = 16'd1;
          1:       tmo = 16'hFFFF;
          default: tmo = 16'($urandom_range(3, 12));
        endcase
        set_config($urandom, retry, settle, tmo);
        useful = 0;
        while (useful < RANDOM_PER_BLOCK) begin
          emulate_card_event(counted);
          if (counted) useful++;
          // hold the sender once per block until the result queue empties
          if (counted && useful == RANDOM_PER_BLOCK / 2) wait_results_drained();
        end
      end
    end
    sink_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (got.issue === 1'b1) cmds_seen++;
      if (got.finished === 1'b1) begin
        if (got.outcome === 1'b1) runs_timeout++;
        else runs_ok++;
      end
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request pending: %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.pad !== want.pad || got.card_ready !== want.card_ready ||
            got.rca !== want.rca || got.outcome !== want.outcome ||
            got.finished !== want.finished || got.arg !== want.arg ||
            got.cmd !== want.cmd || got.issue !== want.issue) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"%0t: mismatch exp issue=%0d cmd=%0d arg=%h fin=%0d out=%0d",
                      " rca=%h rdy=%0d pad=%h"},
                     $time, want.issue, want.cmd, want.arg, want.finished, want.outcome,
                     want.rca, want.card_ready, want.pad);
            $display({"%0t:          got issue=%0d cmd=%0d arg=%h fin=%0d out=%0d",
                      " rca=%h rdy=%0d pad=%h"},
                     $time, got.issue, got.cmd, got.arg, got.finished, got.outcome,
                     got.rca, got.card_ready, got.pad);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_settle();
    test_full_init();
    test_error_paths();
    test_bus_read_errors();
    test_random_traffic();
    wait_results_drained();
    $display("%0d events sent, %0d results checked, %0d mismatches", events_sent, results_seen,
             mismatches);
    $display("%0d commands issued, %0d runs finished ok, %0d with timeout", cmds_seen, runs_ok,
             runs_timeout);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sdio_init_pkg.sv
hw/rtl/sdio_card_init_sequencer.sv
bench/tb_sdio_card_init_sequencer.sv
